// File: rtl/rsp_pkg.sv
package rsp_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int LEN_BITS    = 20;

  localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] KIND_BULK_BYTE = 3'd0;
  localparam logic [2:0] KIND_BULK_END  = 3'd1;
  localparam logic [2:0] KIND_INTEGER   = 3'd2;
  localparam logic [2:0] KIND_ARRAY     = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;
  localparam logic [2:0] KIND_MSG_END   = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic [31:0] value;
    logic [3:0]  level;
    logic [3:0]  closed_levels;
  } tok_t;

  typedef struct packed {
    logic                push;
    logic                finish;
    logic                clear;
    logic [LEN_BITS-1:0] len;
  } stack_op_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] closed;
  } stack_stat_t;

  function automatic logic [3:0] to_nib(input logic [LVL_W-1:0] v);
    logic [LVL_W+3:0] w;
    w = {4'b0, v};
    return w[3:0];
  endfunction

endpackage

// File: rtl/rsp_if.sv
interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_out;
  logic [31:0] value;
  logic [3:0]  level;
  logic [3:0]  closed_levels;

  modport source (output valid, output kind, output byte_out, output value,
                  output level, output closed_levels, input ready);
  modport sink (input valid, input kind, input byte_out, input value,
                input level, input closed_levels, output ready);
endinterface

// File: rtl/rsp_stack.sv
module rsp_stack (
  input  logic                clk,
  input  logic                rst,
  input  rsp_pkg::stack_op_t  op,
  output rsp_pkg::stack_stat_t stat
);
  import rsp_pkg::*;

  logic [LEN_BITS-1:0]  remaining [STACK_DEPTH];
  logic [LVL_W-1:0]     level;
  logic [STACK_DEPTH-1:0] at_last;
  logic                 hit;
  logic [STK_IDX_W-1:0] tgt;
  logic [LVL_W-1:0]     tgt_up;

  // an entry at one or zero closes when an element finishes
  always_comb begin
    for (int j = 0; j < STACK_DEPTH; j++) begin
      at_last[j] = (remaining[j] <= LEN_BITS'(1));
    end
  end

  // highest open entry that survives the finish
  always_comb begin
    hit = 1'b0;
    tgt = '0;
    for (int j = 0; j < STACK_DEPTH; j++) begin
      if ((LVL_W'(j) < level) && !at_last[j]) begin
        hit = 1'b1;
        tgt = STK_IDX_W'(j);
      end
    end
  end

  assign tgt_up      = LVL_W'(tgt) + LVL_W'(1);
  assign stat.level  = level;
  assign stat.closed = hit ? (level - tgt_up) : level;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (op.clear) begin
      level <= '0;
    end else if (op.push) begin
      level <= level + LVL_W'(1);
    end else if (op.finish) begin
      level <= hit ? tgt_up : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      remaining[level[STK_IDX_W-1:0]] <= op.len;
    end else if (op.finish && !op.clear && hit) begin
      remaining[tgt] <= remaining[tgt] - LEN_BITS'(1);
    end
  end

endmodule

// File: rtl/rsp_parse.sv
module rsp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  rsp_pkg::stack_stat_t stat,
  output rsp_pkg::stack_op_t   op,
  output logic                 res_valid,
  output rsp_pkg::tok_t        res
);
  import rsp_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_HSKIP  = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  localparam logic [1:0] TY_BULK  = 2'd0;
  localparam logic [1:0] TY_INT   = 2'd1;
  localparam logic [1:0] TY_ARRAY = 2'd2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  logic [2:0]          phase, phase_next;
  logic [1:0]          item_type, item_type_next;
  logic [LEN_BITS-1:0] length_count, length_count_next;
  logic [31:0]         accumulator, accumulator_next;
  logic                skip_left, skip_left_next;

  logic [LEN_BITS+3:0] len_ext, len_x10;
  logic [31:0]         acc_x10;
  logic                is_digit, len_ovf, stack_full;
  logic [3:0]          lvl4, closed4;
  stack_op_t           op_c;

  assign is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign len_ext    = {4'b0, length_count};
  assign len_x10    = (len_ext << 3) + (len_ext << 1) + {{LEN_BITS{1'b0}}, data_byte[3:0]};
  assign len_ovf    = |len_x10[LEN_BITS+3:LEN_BITS];
  assign acc_x10    = (accumulator << 3) + (accumulator << 1) + {24'b0, data_byte}
                      - 32'd48;
  assign stack_full = (stat.level >= LVL_W'(STACK_DEPTH));
  assign lvl4       = to_nib(stat.level);
  assign closed4    = to_nib(stat.closed);

  always_comb begin
    phase_next        = phase;
    item_type_next    = item_type;
    length_count_next = length_count;
    accumulator_next  = accumulator;
    skip_left_next    = skip_left;
    res_valid         = 1'b0;
    res               = '0;
    op_c              = '0;
    op_c.len          = length_count;

    unique case (phase)
      PH_DIGITS: begin
        if (is_digit) begin
          if (len_ovf) begin
            res_valid         = 1'b1;
            res.kind          = KIND_ERROR;
            res.level         = lvl4;
            phase_next        = PH_IDLE;
            item_type_next    = TY_BULK;
            length_count_next = '0;
            accumulator_next  = '0;
            skip_left_next    = 1'b0;
            op_c.clear        = 1'b1;
          end else begin
            length_count_next = len_x10[LEN_BITS-1:0];
          end
        end else begin
          phase_next = PH_HSKIP;
        end
      end
      PH_HSKIP: begin
        if (item_type == TY_ARRAY) begin
          res_valid  = 1'b1;
          res.kind   = KIND_ARRAY;
          res.value  = {{(32-LEN_BITS){1'b0}}, length_count};
          res.level  = lvl4;
          if ((length_count != '0) && !stack_full) begin
            op_c.push = 1'b1;
          end else begin
            op_c.finish       = 1'b1;
            res.closed_levels = closed4;
          end
          phase_next = PH_IDLE;
        end else begin
          accumulator_next = (item_type == TY_BULK) ?
                             {{(32-LEN_BITS){1'b0}}, length_count} : 32'd0;
          if (length_count != '0) begin
            phase_next = PH_BODY;
          end else begin
            phase_next     = PH_TAIL;
            skip_left_next = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (item_type == TY_BULK) begin
          res_valid    = 1'b1;
          res.kind     = KIND_BULK_BYTE;
          res.byte_out = data_byte;
          res.level    = lvl4;
        end else begin
          accumulator_next = acc_x10;
        end
        if (length_count != '0) begin
          length_count_next = length_count - LEN_BITS'(1);
        end
        if (length_count <= LEN_BITS'(1)) begin
          phase_next     = PH_TAIL;
          skip_left_next = 1'b1;
        end
      end
      PH_TAIL: begin
        if (skip_left) begin
          skip_left_next = 1'b0;
        end else begin
          res_valid         = 1'b1;
          res.kind          = (item_type == TY_BULK) ? KIND_BULK_END : KIND_INTEGER;
          res.value         = accumulator;
          res.level         = lvl4;
          res.closed_levels = closed4;
          op_c.finish       = 1'b1;
          phase_next        = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if ((data_byte == CH_DOLLAR) || (data_byte == CH_COLON) ||
            ((data_byte == CH_STAR) && !stack_full)) begin
          item_type_next    = (data_byte == CH_DOLLAR) ? TY_BULK :
                              (data_byte == CH_COLON)  ? TY_INT  : TY_ARRAY;
          length_count_next = '0;
          accumulator_next  = '0;
          skip_left_next    = 1'b0;
          phase_next        = PH_DIGITS;
        end else if ((data_byte == CH_NUL) && (stat.level == '0)) begin
          res_valid = 1'b1;
          res.kind  = KIND_MSG_END;
        end else begin
          res_valid         = 1'b1;
          res.kind          = KIND_ERROR;
          res.level         = lvl4;
          item_type_next    = TY_BULK;
          length_count_next = '0;
          accumulator_next  = '0;
          skip_left_next    = 1'b0;
          op_c.clear        = 1'b1;
        end
      end
    endcase
  end

  assign op = step ? op_c : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      item_type    <= TY_BULK;
      length_count <= '0;
      accumulator  <= '0;
      skip_left    <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      item_type    <= item_type_next;
      length_count <= length_count_next;
      accumulator  <= accumulator_next;
      skip_left    <= skip_left_next;
    end
  end

endmodule

// File: rtl/resp_stream_parser.sv
// Byte-serial parser for a RESP-style stream. One byte is taken per clock
// cycle, back to back, whenever the output register is empty or being read
// in the same cycle; each byte yields zero or one token, presented in the
// cycle after the byte is taken. The rate is set by the per-byte state update
// (length and integer multiply-by-ten, array stack finish search), which
// is computed combinationally. Tokens carry the array depth around them and
// the number of arrays they complete. No initialization sequence after reset.
module resp_stream_parser (
  input logic        clk,
  input logic        rst,
  rsp_in_if.sink     bytes,
  rsp_out_if.source  tokens
);
  import rsp_pkg::*;

  logic        step;
  logic        res_valid;
  tok_t        res;
  tok_t        tok;
  logic        tok_valid;
  stack_op_t   op;
  stack_stat_t stat;

  assign bytes.ready = !tok_valid || tokens.ready;
  assign step        = bytes.valid && bytes.ready;

  rsp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (bytes.data_byte),
    .stat      (stat),
    .op        (op),
    .res_valid (res_valid),
    .res       (res)
  );

  rsp_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (step && res_valid) begin
      tok_valid <= 1'b1;
    end else if (tokens.ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      tok <= res;
    end
  end

  assign tokens.valid         = tok_valid;
  assign tokens.kind          = tok.kind;
  assign tokens.byte_out      = tok.byte_out;
  assign tokens.value         = tok.value;
  assign tokens.level         = tok.level;
  assign tokens.closed_levels = tok.closed_levels;

endmodule

// File: dv/tb_top.sv
module tb_top;
  import rsp_pkg::*;

  localparam logic [7:0] CH_BULK  = 8'h24;
  localparam logic [7:0] CH_INT   = 8'h3A;
  localparam logic [7:0] CH_ARRAY = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
  localparam int N_BYTES        = 2000;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [2:0] {PH_IDLE, PH_DIGITS, PH_HSKIP, PH_BODY, PH_TAIL} phase_e;
  typedef enum logic [1:0] {IT_BULK, IT_INT, IT_ARRAY} item_e;

  class token_scoreboard;
    phase_e              phase;
    item_e               itype;
    logic [LEN_BITS-1:0] len_cnt;
    logic [31:0]         acc;
    bit                  skip_pending;
    logic [LEN_BITS-1:0] open_cnt [STACK_DEPTH];
    int unsigned         depth;
    tok_t                expected_tokens [$];
    int                  errors;

    function new();
      errors = 0;
      to_top();
    endfunction

    function void to_top();
      phase        = PH_IDLE;
      itype        = IT_BULK;
      len_cnt      = '0;
      acc          = '0;
      skip_pending = 1'b0;
      depth        = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] b, logic [31:0] v,
                       int unsigned lvl, int unsigned closed);
      tok_t t;
      t.kind          = kind;
      t.byte_out      = b;
      t.value         = v;
      t.level         = 4'(lvl);
      t.closed_levels = 4'(closed);
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // count one finished element down through the open arrays
    function int unsigned close_arrays();
      int unsigned closed;
      int unsigned top;
      closed = 0;
      while (depth > 0 && depth <= STACK_DEPTH) begin
        top = depth - 1;
        if (open_cnt[top] != 0) open_cnt[top] = open_cnt[top] - 1'b1;
        if (open_cnt[top] != 0) break;
        depth--;
        closed++;
      end
      return closed;
    endfunction

    function void parse_byte(logic [7:0] b);
      int unsigned     lvl;
      longint unsigned nl;
      lvl = depth;
      case (phase)
        PH_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            nl = 64'(len_cnt) * 64'd10 + 64'(b - CH_ZERO);
            if (nl > LEN_MAX) begin
              emit(KIND_ERROR, 8'd0, 32'd0, lvl, 0);
              to_top();
            end else begin
              len_cnt = LEN_BITS'(nl);
            end
          end else begin
            phase = PH_HSKIP;
          end
        end
        PH_HSKIP: begin
          if (itype == IT_ARRAY) begin
            if (len_cnt != 0 && depth < STACK_DEPTH) begin
              open_cnt[depth] = len_cnt;
              depth++;
              emit(KIND_ARRAY, 8'd0, 32'(len_cnt), lvl, 0);
            end else begin
              emit(KIND_ARRAY, 8'd0, 32'(len_cnt), lvl, close_arrays());
            end
            phase = PH_IDLE;
          end else begin
            acc = (itype == IT_BULK) ? 32'(len_cnt) : 32'd0;
            if (len_cnt != 0) begin
              phase = PH_BODY;
            end else begin
              phase        = PH_TAIL;
              skip_pending = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if (itype == IT_BULK) emit(KIND_BULK_BYTE, b, 32'd0, lvl, 0);
          else acc = acc * 32'd10 + 32'(b) - 32'(CH_ZERO);
          if (len_cnt != 0) len_cnt = len_cnt - 1'b1;
          if (len_cnt == 0) begin
            phase        = PH_TAIL;
            skip_pending = 1'b1;
          end
        end
        PH_TAIL: begin
          if (skip_pending) begin
            skip_pending = 1'b0;
          end else begin
            emit((itype == IT_BULK) ? KIND_BULK_END : KIND_INTEGER, 8'd0, acc, lvl,
                 close_arrays());
            phase = PH_IDLE;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (b == CH_BULK || b == CH_INT || (b == CH_ARRAY && depth < STACK_DEPTH)) begin
            itype        = (b == CH_BULK) ? IT_BULK : (b == CH_INT) ? IT_INT : IT_ARRAY;
            len_cnt      = '0;
            acc          = '0;
            skip_pending = 1'b0;
            phase        = PH_DIGITS;
          end else if (b == CH_NUL && depth == 0) begin
            emit(KIND_MSG_END, 8'd0, 32'd0, 0, 0);
          end else begin
            emit(KIND_ERROR, 8'd0, 32'd0, lvl, 0);
            to_top();
          end
        end
      endcase
    endfunction

    function void match_token(tok_t got);
      tok_t exp_tok;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d value %0h", got.kind, got.value);
        errors++;
        return;
      end
      exp_tok = expected_tokens.pop_front();
      if (got.kind !== exp_tok.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", exp_tok.kind, got.kind);
        errors++;
      end
      if (got.byte_out !== exp_tok.byte_out) begin
        $error("byte_out mismatch: expected %0h, actual %0h", exp_tok.byte_out, got.byte_out);
        errors++;
      end
      if (got.value !== exp_tok.value) begin
        $error("value mismatch: expected %0d, actual %0d", exp_tok.value, got.value);
        errors++;
      end
      if (got.level !== exp_tok.level) begin
        $error("level mismatch: expected %0d, actual %0d", exp_tok.level, got.level);
        errors++;
      end
      if (got.closed_levels !== exp_tok.closed_levels) begin
        $error("closed_levels mismatch: expected %0d, actual %0d",
               exp_tok.closed_levels, got.closed_levels);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rsp_in_if  byte_ch ();
  rsp_out_if tok_ch ();

  resp_stream_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .tokens (tok_ch)
  );

  token_scoreboard sb = new();

  logic [7:0] stim_q [$];
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  bit         src_burst = 1'b0;
  bit         sink_burst = 1'b0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stim_q.insert(stim_q.size(), b);
  endfunction

  function automatic void put_header(logic [7:0] ch, int unsigned n);
    string      s;
    logic [7:0] b;
    add_byte(ch);
    if ($urandom_range(0, 7) == 0) add_byte(CH_ZERO);
    if (n != 0 || $urandom_range(0, 1) == 0) begin
      s = $sformatf("%0d", n);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    end
    if ($urandom_range(0, 3) != 0) begin
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else begin
      do b = any_byte(); while (b >= CH_ZERO && b <= CH_NINE);
      add_byte(b);
      add_byte(any_byte());
    end
  endfunction

  function automatic void put_tail();
    if ($urandom_range(0, 3) != 0) begin
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else begin
      add_byte(any_byte());
      add_byte(any_byte());
    end
  endfunction

  function automatic void put_item(int unsigned open_lv);
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
      put_header(CH_BULK, n);
      repeat (n) add_byte(any_byte());
      put_tail();
    end else if (sel < 7 || open_lv >= STACK_DEPTH) begin
      n = $urandom_range(0, 12);
      put_header(CH_INT, n);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) add_byte(any_byte());
        else add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      put_tail();
    end else begin
      n = $urandom_range(0, (open_lv < 2) ? 3 : 2);
      put_header(CH_ARRAY, n);
      repeat (n) put_item(open_lv + 1);
    end
  endfunction

  function automatic void put_message();
    repeat ($urandom_range(1, 3)) put_item(0);
    add_byte(CH_NUL);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     = 1'b1;
    byte_ch.data_byte = b;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    sb.parse_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stim();
    foreach (stim_q[i]) send_byte(stim_q[i]);
    stim_q.delete();
  endtask

  task automatic drain();
    byte_ch.valid = 1'b0;
    while (sb.expected_tokens.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // token sink with random back-pressure
  initial begin
    int   stall;
    tok_t got;
    tok_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        tok_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      tok_ch.ready = 1'b1;
      do @(posedge clk); while (tok_ch.valid !== 1'b1 || rst);
      got.kind          = tok_ch.kind;
      got.byte_out      = tok_ch.byte_out;
      got.value         = tok_ch.value;
      got.level         = tok_ch.level;
      got.closed_levels = tok_ch.closed_levels;
      sb.match_token(got);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int  sel;
    int  cut;
    bit  mid_pause_done;
    mid_pause_done    = 1'b0;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'd0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: message end, bulk extremes, empty integer, empty array,
    // unknown type, zero inside an array, length overflow
    add_byte(CH_NUL);
    put_header(CH_BULK, 2);
    add_byte(8'hFF);
    add_byte(8'h00);
    put_tail();
    put_header(CH_INT, 0);
    put_tail();
    put_header(CH_ARRAY, 0);
    add_byte(8'h41);
    put_header(CH_ARRAY, 1);
    add_byte(CH_NUL);
    put_header(CH_BULK, 1048576);
    send_stim();
    drain();

    while (bytes_sent < N_BYTES) begin
      src_burst = ($urandom_range(0, 7) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        put_message();
      end else if (sel < 16) begin
        repeat ($urandom_range(1, 8)) add_byte(any_byte());
      end else if (sel < 18) begin
        put_message();
        if ($urandom_range(0, 1) == 0) begin
          stim_q[$urandom_range(0, stim_q.size() - 1)] = any_byte();
        end else begin
          cut = $urandom_range(1, stim_q.size());
          while (stim_q.size() > cut) void'(stim_q.pop_back());
        end
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            repeat (STACK_DEPTH) put_header(CH_ARRAY, 1);
            put_item(STACK_DEPTH);
            add_byte(CH_NUL);
          end
          1: begin
            repeat (STACK_DEPTH) put_header(CH_ARRAY, 2);
            add_byte(CH_ARRAY);
            add_byte(CH_NUL);
          end
          2: begin
            put_header(CH_ARRAY, 32'(LEN_MAX));
            add_byte(CH_NUL);
          end
          default: begin
            put_header(($urandom_range(0, 1) == 0) ? CH_BULK : CH_INT,
                       $urandom_range(32'(LEN_MAX) + 1, 32'hFFFF_FFFF));
            add_byte(CH_NUL);
          end
        endcase
      end
      send_stim();
      if (!mid_pause_done && bytes_sent >= N_BYTES / 2) begin
        drain();
        mid_pause_done = 1'b1;
      end
    end
    drain();

    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: resp_stream_parser.f
rtl/rsp_pkg.sv
rtl/rsp_if.sv
rtl/rsp_stack.sv
rtl/rsp_parse.sv
rtl/resp_stream_parser.sv
dv/tb_top.sv
